FILE: rtl/core/srcs_pkg.sv
`timescale 1ns / 1ps

package srcs_pkg;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_RADIO_TIMEOUT     = 3'd0;
    localparam logic [2:0] REG_COMPANION_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_SAIL_DEAD_BAND    = 3'd2;
    localparam logic [2:0] REG_MOTOR_FULL_DUTY   = 3'd3;
    localparam logic [2:0] REG_RUDDER_CENTER_PWM = 3'd4;

    // Register values after reset.
    localparam logic [19:0] RADIO_TIMEOUT_RST     = 20'd2000;
    localparam logic [19:0] COMPANION_TIMEOUT_RST = 20'd10000;
    localparam logic [11:0] SAIL_DEAD_BAND_RST    = 12'd320;
    localparam logic [15:0] MOTOR_FULL_DUTY_RST   = 16'd12800;
    localparam logic [11:0] RUDDER_CENTER_PWM_RST = 12'd1370;

    // Angles in 1/16 degree.
    localparam logic signed [15:0] HALF_TURN = 16'sd2880;
    localparam logic signed [15:0] FULL_TURN = 16'sd5760;

    // Rudder pulse scaling: pwm = floor((center * 9 + angle * 5) / 9).
    localparam logic signed [16:0] CENTER_SCALE = 17'sd9;
    localparam logic signed [16:0] ANGLE_SCALE  = 17'sd5;
    // Reciprocal of 9 with a 19-bit shift; exact for dividends below 2^16.
    localparam logic [15:0] DIV9_RECIP = 16'd58255;
    localparam logic [11:0] PWM_MAX    = 12'd4095;

    // Configuration values handed from the register file to the datapath.
    typedef struct packed {
        logic [19:0] radio_timeout;
        logic [19:0] companion_timeout;
        logic [11:0] dead_band;
        logic [15:0] full_duty;
        logic [11:0] center_pwm;
    } srcs_cfg_t;

endpackage

FILE: rtl/core/srcs_cfg_regs.sv
`timescale 1ns / 1ps

module srcs_cfg_regs
    import srcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output srcs_cfg_t   cfg
);

    srcs_cfg_t   cfg_reg;
    srcs_cfg_t   cfg_next;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Write decode; an index past the last register is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_RADIO_TIMEOUT:     cfg_next.radio_timeout     = pwdata[19:0];
                REG_COMPANION_TIMEOUT: cfg_next.companion_timeout = pwdata[19:0];
                REG_SAIL_DEAD_BAND:    cfg_next.dead_band         = pwdata[11:0];
                REG_MOTOR_FULL_DUTY:   cfg_next.full_duty         = pwdata[15:0];
                REG_RUDDER_CENTER_PWM: cfg_next.center_pwm        = pwdata[11:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radio_timeout     <= RADIO_TIMEOUT_RST;
            cfg_reg.companion_timeout <= COMPANION_TIMEOUT_RST;
            cfg_reg.dead_band         <= SAIL_DEAD_BAND_RST;
            cfg_reg.full_duty         <= MOTOR_FULL_DUTY_RST;
            cfg_reg.center_pwm        <= RUDDER_CENTER_PWM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (reg_idx)
            REG_RADIO_TIMEOUT:     prdata = {12'd0, cfg_reg.radio_timeout};
            REG_COMPANION_TIMEOUT: prdata = {12'd0, cfg_reg.companion_timeout};
            REG_SAIL_DEAD_BAND:    prdata = {20'd0, cfg_reg.dead_band};
            REG_MOTOR_FULL_DUTY:   prdata = {16'd0, cfg_reg.full_duty};
            REG_RUDDER_CENTER_PWM: prdata = {20'd0, cfg_reg.center_pwm};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/core/sail_rudder_command_selector.sv
`timescale 1ns / 1ps

// Sail and rudder command selector. An item is taken at any clock edge where
// start is high; busy stays low, so a new item can be given every cycle. Each
// item yields one result after passing through the input register and then the
// result register, with all selection, angle wrapping and rudder scaling done
// in the logic between them. done is high for exactly one cycle with the result
// on the output ports; the receiver cannot stall, so it must take the result in
// that cycle. The user must write configuration through the APB port only while
// no item is in flight; the block itself does not enforce it.
module sail_rudder_command_selector
    import srcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Item input
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        now_ms,
    input  logic               radio_seen,
    input  logic [31:0]        radio_stamp_ms,
    input  logic signed [13:0] radio_sail,
    input  logic signed [11:0] radio_rudder,
    input  logic               companion_seen,
    input  logic [31:0]        companion_stamp_ms,
    input  logic signed [13:0] companion_sail,
    input  logic signed [11:0] companion_rudder,
    input  logic [12:0]        encoder_angle,
    // Result output
    output logic               done,
    output logic               radio_valid,
    output logic               companion_valid,
    output logic signed [13:0] sail_target,
    output logic signed [11:0] rudder_target,
    output logic [15:0]        motor_a_duty,
    output logic [15:0]        motor_b_duty,
    output logic [11:0]        rudder_pulse,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    srcs_cfg_t cfg;

    srcs_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input register stage.
    logic               in_valid_reg;
    logic [31:0]        now_reg;
    logic               r_seen_reg;
    logic [31:0]        r_stamp_reg;
    logic signed [13:0] r_sail_reg;
    logic signed [11:0] r_rud_reg;
    logic               c_seen_reg;
    logic [31:0]        c_stamp_reg;
    logic signed [13:0] c_sail_reg;
    logic signed [11:0] c_rud_reg;
    logic [12:0]        enc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg     <= now_ms;
            r_seen_reg  <= radio_seen;
            r_stamp_reg <= radio_stamp_ms;
            r_sail_reg  <= radio_sail;
            r_rud_reg   <= radio_rudder;
            c_seen_reg  <= companion_seen;
            c_stamp_reg <= companion_stamp_ms;
            c_sail_reg  <= companion_sail;
            c_rud_reg   <= companion_rudder;
            enc_reg     <= encoder_angle;
        end
    end

    // Datapath between the two register stages.
    logic [31:0]        r_age;
    logic [31:0]        c_age;
    logic               rv;
    logic               cv;
    logic signed [13:0] sail_sel;
    logic signed [11:0] rud_sel;
    logic signed [15:0] tgt_raw;
    logic signed [15:0] tgt_mod;
    logic signed [15:0] err_raw;
    logic signed [15:0] err;
    logic signed [15:0] band;
    logic [15:0]        duty_a;
    logic [15:0]        duty_b;
    logic signed [16:0] num;
    logic [31:0]        prod;
    logic [12:0]        quot;
    logic [11:0]        pwm;

    always_comb
    begin
        // Freshness of each source, age taken modulo 2^32.
        r_age = now_reg - r_stamp_reg;
        c_age = now_reg - c_stamp_reg;
        rv    = r_seen_reg && (r_age < {12'd0, cfg.radio_timeout});
        cv    = c_seen_reg && (c_age < {12'd0, cfg.companion_timeout});

        // Source choice; with both valid the radio wins unless its value is zero.
        if (rv && cv)
        begin
            sail_sel = (r_sail_reg != 14'sd0) ? r_sail_reg : c_sail_reg;
            rud_sel  = (r_rud_reg != 12'sd0) ? r_rud_reg : c_rud_reg;
        end
        else if (rv)
        begin
            sail_sel = r_sail_reg;
            rud_sel  = r_rud_reg;
        end
        else if (cv)
        begin
            sail_sel = c_sail_reg;
            rud_sel  = c_rud_reg;
        end
        else
        begin
            sail_sel = 14'sd0;
            rud_sel  = 12'sd0;
        end

        // Target on the encoder scale; the input range needs one step at most.
        tgt_raw = HALF_TURN + {{2{sail_sel[13]}}, sail_sel};
        if (tgt_raw >= FULL_TURN)
            tgt_mod = tgt_raw - FULL_TURN;
        else if (tgt_raw < 16'sd0)
            tgt_mod = tgt_raw + FULL_TURN;
        else
            tgt_mod = tgt_raw;

        // Error wrapped to half a turn either way; one step covers every encoder value.
        err_raw = tgt_mod - $signed({3'd0, enc_reg});
        if (err_raw > HALF_TURN)
            err = err_raw - FULL_TURN;
        else if (err_raw < -HALF_TURN)
            err = err_raw + FULL_TURN;
        else
            err = err_raw;

        // Bang-bang drive; the band edge itself counts as inside.
        band   = $signed({4'd0, cfg.dead_band});
        duty_a = 16'd0;
        duty_b = 16'd0;
        if (err > band)
            duty_a = cfg.full_duty;
        else if (err < -band)
            duty_b = cfg.full_duty;

        // Rudder pulse: floor division by 9 via reciprocal; negatives clamp to zero, overflow to PWM_MAX.
        num  = $signed({5'd0, cfg.center_pwm}) * CENTER_SCALE
             + $signed({{5{rud_sel[11]}}, rud_sel}) * ANGLE_SCALE;
        prod = num[15:0] * DIV9_RECIP;
        quot = prod[31:19];
        if (num[16])
            pwm = 12'd0;
        else if (quot > {1'b0, PWM_MAX})
            pwm = PWM_MAX;
        else
            pwm = quot[11:0];
    end

    // Result register stage.
    logic               done_reg;
    logic               rv_reg;
    logic               cv_reg;
    logic signed [13:0] sail_tgt_reg;
    logic signed [11:0] rud_tgt_reg;
    logic [15:0]        duty_a_reg;
    logic [15:0]        duty_b_reg;
    logic [11:0]        pwm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            rv_reg       <= rv;
            cv_reg       <= cv;
            sail_tgt_reg <= sail_sel;
            rud_tgt_reg  <= rud_sel;
            duty_a_reg   <= duty_a;
            duty_b_reg   <= duty_b;
            pwm_reg      <= pwm;
        end
    end

    assign done            = done_reg;
    assign radio_valid     = rv_reg;
    assign companion_valid = cv_reg;
    assign sail_target     = sail_tgt_reg;
    assign rudder_target   = rud_tgt_reg;
    assign motor_a_duty    = duty_a_reg;
    assign motor_b_duty    = duty_b_reg;
    assign rudder_pulse    = pwm_reg;

    // Every accepted item produces a result once it has passed the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted item produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |=> !done)
        else $error("result strobe without an item in flight");

    // The two motor channels are never driven together.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (motor_a_duty == 16'd0 || motor_b_duty == 16'd0))
        else $error("both motor channels active");

    // With no valid source both targets are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !radio_valid && !companion_valid)
            |-> (sail_target == 14'sd0 && rudder_target == 12'sd0))
        else $error("nonzero target with no valid source");

endmodule
